// ===== sv/pfg_pkg.sv =====
// shared constants, types and helpers of the particle force generator
package pfg_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int IDX_W = $clog2(CORDIC_STEPS);

	localparam int FIELD_W = 20;
	localparam int FREQ_W  = 16;
	localparam int TIME_W  = 32;
	localparam int SEED_W  = 32;
	localparam int ANG_W   = 49;
	localparam int MAG_W   = 48;
	localparam int TRIG_W  = 18;
	localparam int ROT_W   = 20;
	localparam int MA_W    = 33;
	localparam int MB_W    = 21;
	localparam int P_W     = MA_W + MB_W;

	// angle reduction by reciprocal: quotient from the top bits, then one fix-up
	localparam int RED_LO  = 22;
	localparam int RCP_W   = 28;
	localparam int RCP_SH  = 32;
	localparam int RCP_P_W = MAG_W - RED_LO + RCP_W;
	localparam int QUO_W   = RCP_P_W - RCP_SH;
	localparam int REM_W   = 28;

	localparam logic [MAG_W-1:0] TWO_PI_Q24 = 48'd105414357;
	// floor(2^54 / two pi in q24)
	localparam logic [RCP_W-1:0] TWO_PI_RCP = 28'd170891319;
	localparam logic signed [ROT_W-1:0] TWO_PI_Q16  = 20'sd411775;
	localparam logic signed [ROT_W-1:0] PI_Q16      = 20'sd205887;
	localparam logic signed [ROT_W-1:0] HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [ROT_W-1:0] CORDIC_GAIN = 20'sd39797;
	localparam logic signed [MB_W-1:0]  LCG_MUL_B   = 21'sd214013;
	localparam logic [SEED_W-1:0]       LCG_ADD     = 32'd2531011;
	localparam logic signed [MB_W-1:0]  DEG_TO_RAD  = 21'sd292818;

	localparam logic [1:0] KIND_RAND = 2'd1;
	localparam logic [1:0] KIND_SINE = 2'd2;

	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
	localparam logic [OP_W-1:0] OP_SEED  = 4'd1;
	localparam logic [OP_W-1:0] OP_RAND  = 4'd2;
	localparam logic [OP_W-1:0] OP_PHASE = 4'd3;
	localparam logic [OP_W-1:0] OP_SPOL  = 4'd4;
	localparam logic [OP_W-1:0] OP_SCART = 4'd5;
	localparam logic [OP_W-1:0] OP_DEG1  = 4'd6;
	localparam logic [OP_W-1:0] OP_DEG2  = 4'd7;
	localparam logic [OP_W-1:0] OP_ASC   = 4'd8;
	localparam logic [OP_W-1:0] OP_ACC   = 4'd9;
	localparam logic [OP_W-1:0] OP_RESA  = 4'd10;
	localparam logic [OP_W-1:0] OP_RESS  = 4'd11;

	localparam logic [2:0] REG_COORD = 3'd0;
	localparam logic [2:0] REG_KINDS = 3'd1;
	localparam logic [2:0] REG_MIN   = 3'd2;
	localparam logic [2:0] REG_MAX   = 3'd3;
	localparam logic [2:0] REG_FREQ  = 3'd4;

	typedef struct packed {
		logic            load_t;
		logic [OP_W-1:0] op;
		logic [1:0]      axis;
		logic [1:0]      ridx;
		logic            clr_comp;
		logic            sc_start;
		logic            cap_az;
		logic            cap_inc;
		logic            res_zero;
		logic            res_from_comp;
		logic            load_out;
	} cmd_t;

	typedef struct packed {
		logic sc_done;
		logic ang_zero;
	} sts_t;

	function automatic logic signed [ROT_W-1:0] atan_q16(input logic [4:0] idx);
		logic signed [ROT_W-1:0] v;
		unique case (idx)
			5'd0:  v = 20'sd51472;
			5'd1:  v = 20'sd30386;
			5'd2:  v = 20'sd16055;
			5'd3:  v = 20'sd8150;
			5'd4:  v = 20'sd4091;
			5'd5:  v = 20'sd2047;
			5'd6:  v = 20'sd1024;
			5'd7:  v = 20'sd512;
			5'd8:  v = 20'sd256;
			5'd9:  v = 20'sd128;
			5'd10: v = 20'sd64;
			5'd11: v = 20'sd32;
			5'd12: v = 20'sd16;
			5'd13: v = 20'sd8;
			5'd14: v = 20'sd4;
			5'd15: v = 20'sd2;
			5'd16: v = 20'sd1;
			default: v = 20'sd0;
		endcase
		return v;
	endfunction

	function automatic logic signed [FIELD_W-1:0] sat20(input logic signed [P_W-1:0] v);
		logic signed [FIELD_W-1:0] r;
		if (v > P_W'(524287))
			r = 20'sd524287;
		else if (v < -P_W'(524288))
			r = -20'sd524288;
		else
			r = FIELD_W'(v);
		return r;
	endfunction

endpackage

// ===== sv/pfg_sincos.sv =====
// iterative sine and cosine: modulo 2*pi reduction, quadrant fold, cordic rotation
module pfg_sincos (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [pfg_pkg::ANG_W-1:0]     ang,
	output logic                                 done,
	output logic signed [pfg_pkg::TRIG_W-1:0]    sin_val,
	output logic signed [pfg_pkg::TRIG_W-1:0]    cos_val
);
	import pfg_pkg::*;

	localparam logic [2:0] SC_IDLE = 3'd0;
	localparam logic [2:0] SC_QUO  = 3'd1;
	localparam logic [2:0] SC_SUB  = 3'd2;
	localparam logic [2:0] SC_FIX  = 3'd3;
	localparam logic [2:0] SC_FOLD = 3'd4;
	localparam logic [2:0] SC_ROT  = 3'd5;

	logic [2:0]              st_q;
	logic                    neg_q, flip_q, done_q;
	logic [MAG_W-1:0]        rem_q;
	logic [QUO_W-1:0]        quo_q;
	logic [IDX_W-1:0]        i_q;
	logic signed [ROT_W-1:0] r_q, x_q, y_q;
	logic signed [TRIG_W-1:0] sin_q, cos_q;

	logic [RCP_P_W-1:0]      rcp_p;
	logic [REM_W-1:0]        qc_p, sub_d;
	logic [26:0]             rr;
	logic signed [ROT_W-1:0] r16, xs, ys, at, nx, ny, fx, fy;
	logic                    fl;

	function automatic logic signed [TRIG_W-1:0] clamp_unit(input logic signed [ROT_W-1:0] v);
		logic signed [TRIG_W-1:0] r;
		if (v > 20'sd65536)
			r = 18'sd65536;
		else if (v < -20'sd65536)
			r = -18'sd65536;
		else
			r = TRIG_W'(v);
		return r;
	endfunction

	always_comb begin
		// quotient estimate is low by at most one
		rcp_p = RCP_P_W'(rem_q[MAG_W-1:RED_LO]) * RCP_P_W'(TWO_PI_RCP);
		qc_p  = REM_W'(quo_q) * REM_W'(TWO_PI_Q24);
		sub_d = rem_q[REM_W-1:0] - qc_p;
		rr = rem_q[26:0];
		if (neg_q && rr != 27'd0)
			rr = 27'(TWO_PI_Q24) - rr;
		r16 = ROT_W'({1'b0, rr[26:8]});
		fl = 1'b0;
		if (r16 >= PI_Q16)
			r16 = r16 - TWO_PI_Q16;
		if (r16 > HALF_PI_Q16) begin
			r16 = r16 - PI_Q16;
			fl = 1'b1;
		end else if (r16 < -HALF_PI_Q16) begin
			r16 = r16 + PI_Q16;
			fl = 1'b1;
		end
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = atan_q16(5'(i_q));
		if (r_q >= 0) begin
			nx = x_q - ys;
			ny = y_q + xs;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
		end
		fx = flip_q ? -nx : nx;
		fy = flip_q ? -ny : ny;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= SC_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				SC_IDLE: if (start) st_q <= SC_QUO;
				SC_QUO:  st_q <= SC_SUB;
				SC_SUB:  st_q <= SC_FIX;
				SC_FIX:  st_q <= SC_FOLD;
				SC_FOLD: st_q <= SC_ROT;
				SC_ROT: begin
					if (i_q == IDX_W'(CORDIC_STEPS - 1)) begin
						st_q   <= SC_IDLE;
						done_q <= 1'b1;
					end
				end
				default: st_q <= SC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			SC_IDLE: begin
				neg_q <= ang[ANG_W-1];
				rem_q <= ang[ANG_W-1] ? MAG_W'(-ang) : MAG_W'(ang);
			end
			SC_QUO: quo_q <= rcp_p[RCP_P_W-1:RCP_SH];
			SC_SUB: rem_q <= MAG_W'(sub_d);
			SC_FIX: begin
				if (rem_q >= TWO_PI_Q24)
					rem_q <= rem_q - TWO_PI_Q24;
			end
			SC_FOLD: begin
				r_q    <= r16;
				flip_q <= fl;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				i_q    <= '0;
			end
			SC_ROT: begin
				x_q <= nx;
				y_q <= ny;
				r_q <= (r_q >= 0) ? r_q - at : r_q + at;
				i_q <= i_q + IDX_W'(1);
				if (i_q == IDX_W'(CORDIC_STEPS - 1)) begin
					sin_q <= clamp_unit(fy);
					cos_q <= clamp_unit(fx);
				end
			end
			default: ;
		endcase
	end

	assign done    = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule

// ===== sv/pfg_datapath.sv =====
// datapath: shared multiplier, seed, components, angles, results and output register
module pfg_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pfg_pkg::cmd_t                       cmd,
	output pfg_pkg::sts_t                       sts,
	input  logic [pfg_pkg::TIME_W-1:0]          time_now,
	input  logic [59:0]                         min_values,
	input  logic [59:0]                         max_values,
	input  logic [47:0]                         freq_values,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_x,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_y,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_z
);
	import pfg_pkg::*;

	logic [TIME_W-1:0]        t_q;
	logic [SEED_W-1:0]        seed_q;
	logic signed [FIELD_W-1:0] comp_q [3];
	logic signed [FIELD_W-1:0] res_q [3];
	logic signed [FIELD_W-1:0] out_q [3];
	logic signed [TRIG_W-1:0] sa_q, ca_q, si_q, ci_q, a_q;
	logic signed [ANG_W-1:0]  ang_q;

	logic signed [P_W-1:0]    p_s1;
	logic [OP_W-1:0]          op_s1;
	logic [1:0]               axis_s1, ridx_s1;

	logic signed [FIELD_W-1:0] mn, mx, mn_a;
	logic signed [FREQ_W-1:0]  fr;
	logic signed [FIELD_W:0]   diff;
	logic signed [MA_W-1:0]    ma;
	logic signed [MB_W-1:0]    mb;
	logic signed [P_W-1:0]     rnd, trn;
	logic                      sc_done;
	logic signed [TRIG_W-1:0]  sc_sin, sc_cos, sabs;

	pfg_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.sc_start),
		.ang     (ang_q),
		.done    (sc_done),
		.sin_val (sc_sin),
		.cos_val (sc_cos)
	);

	// operand selection for the shared multiplier
	always_comb begin
		mn   = min_values[FIELD_W*cmd.axis +: FIELD_W];
		mx   = max_values[FIELD_W*cmd.axis +: FIELD_W];
		fr   = freq_values[FREQ_W*cmd.axis +: FREQ_W];
		diff = (FIELD_W+1)'(mx) - (FIELD_W+1)'(mn);
		sabs = sc_sin[TRIG_W-1] ? -sc_sin : sc_sin;
		ma   = '0;
		mb   = '0;
		unique case (cmd.op)
			OP_SEED:  begin ma = MA_W'({1'b0, seed_q}); mb = LCG_MUL_B; end
			OP_RAND:  begin ma = MA_W'(diff); mb = MB_W'({1'b0, seed_q[31:16]}); end
			OP_PHASE: begin ma = MA_W'({1'b0, t_q}); mb = MB_W'(fr); end
			OP_SPOL:  begin ma = MA_W'(diff); mb = MB_W'(sabs); end
			OP_SCART: begin ma = MA_W'(sc_sin); mb = MB_W'(mn); end
			OP_DEG1:  begin ma = MA_W'(comp_q[1]); mb = DEG_TO_RAD; end
			OP_DEG2:  begin ma = MA_W'(comp_q[2]); mb = DEG_TO_RAD; end
			OP_ASC:   begin ma = MA_W'(sa_q); mb = MB_W'(ci_q); end
			OP_ACC:   begin ma = MA_W'(ca_q); mb = MB_W'(ci_q); end
			OP_RESA:  begin ma = MA_W'(a_q); mb = MB_W'(comp_q[0]); end
			OP_RESS:  begin ma = MA_W'(si_q); mb = MB_W'(comp_q[0]); end
			default:  begin ma = '0; mb = '0; end
		endcase
		mn_a = min_values[FIELD_W*axis_s1 +: FIELD_W];
		rnd  = (p_s1 + P_W'(32768)) >>> 16;
		trn  = p_s1 >>> 16;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (op_s1 == OP_SEED) begin
			seed_q <= p_s1[SEED_W-1:0] + LCG_ADD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			op_s1 <= OP_NONE;
		else
			op_s1 <= cmd.op;
	end

	always_ff @(posedge clk) begin
		p_s1    <= ma * mb;
		axis_s1 <= cmd.axis;
		ridx_s1 <= cmd.ridx;
		if (cmd.load_t)
			t_q <= time_now;
		if (cmd.clr_comp)
			comp_q[cmd.axis] <= '0;
		if (cmd.cap_az) begin
			sa_q <= sc_sin;
			ca_q <= sc_cos;
		end
		if (cmd.cap_inc) begin
			si_q <= sc_sin;
			ci_q <= sc_cos;
		end
		if (cmd.res_zero) begin
			for (int i = 0; i < 3; i++)
				res_q[i] <= '0;
		end
		if (cmd.res_from_comp) begin
			for (int i = 0; i < 3; i++)
				res_q[i] <= comp_q[i];
		end
		if (cmd.load_out) begin
			for (int i = 0; i < 3; i++)
				out_q[i] <= res_q[i];
		end
		unique case (op_s1)
			OP_RAND:  comp_q[axis_s1] <= sat20(trn + P_W'(mn_a));
			OP_PHASE: ang_q <= p_s1[ANG_W-1:0];
			OP_SPOL:  comp_q[axis_s1] <= sat20(rnd + P_W'(mn_a));
			OP_SCART: comp_q[axis_s1] <= sat20(rnd);
			OP_DEG1, OP_DEG2: ang_q <= ANG_W'(p_s1 >>> 8);
			OP_ASC, OP_ACC:   a_q <= TRIG_W'(rnd);
			OP_RESA, OP_RESS: res_q[ridx_s1] <= sat20(rnd);
			default: ;
		endcase
	end

	assign sts.sc_done  = sc_done;
	assign sts.ang_zero = (comp_q[1] == '0) && (comp_q[2] == '0);
	assign force_x = out_q[0];
	assign force_y = out_q[1];
	assign force_z = out_q[2];

endmodule

// ===== sv/pfg_ctrl.sv =====
// controller: sequences axis work, polar conversion and the output beat
module pfg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	input  logic          coord_system,
	input  logic [5:0]    axis_kinds,
	output pfg_pkg::cmd_t cmd,
	input  pfg_pkg::sts_t sts
);
	import pfg_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_AXIS  = 5'd1;
	localparam logic [4:0] S_WAIT  = 5'd2;
	localparam logic [4:0] S_RAND  = 5'd3;
	localparam logic [4:0] S_SCGO  = 5'd4;
	localparam logic [4:0] S_SCWT  = 5'd5;
	localparam logic [4:0] S_SMUL  = 5'd6;
	localparam logic [4:0] S_NEXT  = 5'd7;
	localparam logic [4:0] S_CART  = 5'd8;
	localparam logic [4:0] S_POL   = 5'd9;
	localparam logic [4:0] S_AZGO  = 5'd10;
	localparam logic [4:0] S_AZWT  = 5'd11;
	localparam logic [4:0] S_INCGO = 5'd12;
	localparam logic [4:0] S_INCWT = 5'd13;
	localparam logic [4:0] S_MA1   = 5'd14;
	localparam logic [4:0] S_MR0   = 5'd15;
	localparam logic [4:0] S_MA2   = 5'd16;
	localparam logic [4:0] S_MR2   = 5'd17;
	localparam logic [4:0] S_MR1   = 5'd18;
	localparam logic [4:0] S_FIN   = 5'd19;

	logic [4:0] state_q, state_d, ret_q, ret_d;
	logic [1:0] axis_q, axis_d, kind;
	logic       out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		axis_d  = axis_q;
		cmd     = '0;
		cmd.axis = axis_q;
		kind    = axis_kinds[2*axis_q +: 2];
		unique case (state_q)
			S_IDLE: if (in_valid) begin
				cmd.load_t = 1'b1;
				axis_d     = 2'd0;
				state_d    = S_AXIS;
			end
			S_AXIS: begin
				if (kind == KIND_RAND) begin
					cmd.op = OP_SEED; ret_d = S_RAND; state_d = S_WAIT;
				end else if (kind == KIND_SINE) begin
					cmd.op = OP_PHASE; ret_d = S_SCGO; state_d = S_WAIT;
				end else begin
					cmd.clr_comp = 1'b1; state_d = S_NEXT;
				end
			end
			S_WAIT: state_d = ret_q;
			S_RAND: begin cmd.op = OP_RAND; ret_d = S_NEXT; state_d = S_WAIT; end
			S_SCGO: begin cmd.sc_start = 1'b1; state_d = S_SCWT; end
			S_SCWT: if (sts.sc_done) state_d = S_SMUL;
			S_SMUL: begin
				cmd.op  = coord_system ? OP_SPOL : OP_SCART;
				ret_d   = S_NEXT;
				state_d = S_WAIT;
			end
			S_NEXT: begin
				if (axis_q == 2'd2)
					state_d = coord_system ? S_POL : S_CART;
				else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_AXIS;
				end
			end
			S_CART: begin cmd.res_from_comp = 1'b1; state_d = S_FIN; end
			S_POL: begin
				if (sts.ang_zero) begin
					cmd.res_zero = 1'b1; state_d = S_FIN;
				end else begin
					cmd.op = OP_DEG1; ret_d = S_AZGO; state_d = S_WAIT;
				end
			end
			S_AZGO: begin cmd.sc_start = 1'b1; state_d = S_AZWT; end
			S_AZWT: if (sts.sc_done) begin
				cmd.cap_az = 1'b1;
				cmd.op     = OP_DEG2;
				ret_d      = S_INCGO;
				state_d    = S_WAIT;
			end
			S_INCGO: begin cmd.sc_start = 1'b1; state_d = S_INCWT; end
			S_INCWT: if (sts.sc_done) begin
				cmd.cap_inc = 1'b1; state_d = S_MA1;
			end
			S_MA1: begin cmd.op = OP_ASC; ret_d = S_MR0; state_d = S_WAIT; end
			S_MR0: begin
				cmd.op = OP_RESA; cmd.ridx = 2'd0; ret_d = S_MA2; state_d = S_WAIT;
			end
			S_MA2: begin cmd.op = OP_ACC; ret_d = S_MR2; state_d = S_WAIT; end
			S_MR2: begin
				cmd.op = OP_RESA; cmd.ridx = 2'd2; ret_d = S_MR1; state_d = S_WAIT;
			end
			S_MR1: begin
				cmd.op = OP_RESS; cmd.ridx = 2'd1; ret_d = S_FIN; state_d = S_WAIT;
			end
			S_FIN: if (!out_valid_q || !out_stall) begin
				cmd.load_out = 1'b1; state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		if (cmd.load_out)
			out_valid_d = 1'b1;
		else if (!out_stall)
			out_valid_d = 1'b0;
		else
			out_valid_d = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			axis_q      <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ret_q       <= ret_d;
			axis_q      <= axis_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("output register overwritten while a beat waits");
	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sc_done |-> (state_q == S_SCWT || state_q == S_AZWT || state_q == S_INCWT))
		else $error("sincos finished with nobody waiting");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && state_q == S_IDLE) |=> (state_q == S_AXIS))
		else $error("accepted beat did not start axis work");
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AXIS) |-> (axis_q != 2'd3))
		else $error("axis counter ran past z");

endmodule

// ===== sv/particle_force_generator_unit.sv =====
// top level of the particle force generator: config registers, controller and datapath
//
//  channel  direction  handshake                     payload
//  in       to block   in_valid / in_stall           time_now (Q16.16)
//  out      from block out_valid / out_stall         force_x, force_y, force_z (Q12.8)
//  config   to block   apb psel/penable/pwrite       paddr, pwdata, prdata
//
// one item at a time; each item walks the three axes (none, random or sine), then
//   the cartesian step or the polar step, which is short with both angles zero; the
//   sincos unit runs 3 reduction steps, 1 fold and 16 cordic steps, then signals done
// the result waits in the output register, so the next beat is taken meanwhile
// reset clears the random seed, config and control state, not datapath values; no clearing pass
module particle_force_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pfg_pkg::TIME_W-1:0]          time_now,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_x,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_y,
	output logic signed [pfg_pkg::FIELD_W-1:0]  force_z,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [5:0]                          paddr,
	input  logic [63:0]                         pwdata,
	output logic [63:0]                         prdata,
	output logic                                pready
);
	import pfg_pkg::*;

	// configuration registers, 8 bytes apart
	logic        coord_q;
	logic [5:0]  kinds_q;
	logic [59:0] min_q, max_q;
	logic [47:0] freq_q;
	logic        wr_en;
	logic [2:0]  reg_idx;

	cmd_t cmd;
	sts_t sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= 1'b0;
			kinds_q <= '0;
			min_q   <= '0;
			max_q   <= '0;
			freq_q  <= '0;
		end else if (wr_en) begin
			// writes beyond the register list fall through
			unique case (reg_idx)
				REG_COORD: coord_q <= pwdata[0];
				REG_KINDS: kinds_q <= pwdata[5:0];
				REG_MIN:   min_q   <= pwdata[59:0];
				REG_MAX:   max_q   <= pwdata[59:0];
				REG_FREQ:  freq_q  <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COORD: prdata = {63'd0, coord_q};
			REG_KINDS: prdata = {58'd0, kinds_q};
			REG_MIN:   prdata = {4'd0, min_q};
			REG_MAX:   prdata = {4'd0, max_q};
			REG_FREQ:  prdata = {16'd0, freq_q};
			default:   prdata = '0;
		endcase
	end

	// state machine: accepts a beat, walks the axes, then the cartesian or polar step
	pfg_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.coord_system (coord_q),
		.axis_kinds   (kinds_q),
		.cmd          (cmd),
		.sts          (sts)
	);

	// shared multiplier, sincos unit, seed and result registers
	pfg_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.time_now    (time_now),
		.min_values  (min_q),
		.max_values  (max_q),
		.freq_values (freq_q),
		.force_x     (force_x),
		.force_y     (force_y),
		.force_z     (force_z)
	);

endmodule
